// ----- rtl/rigid_point_transform_filter_assert.svh -----
// assertion macros shared by the checker of the point transform filter
// depends on nothing; included by files that assert
`ifndef RIGID_POINT_TRANSFORM_FILTER_ASSERT_SVH
`define RIGID_POINT_TRANSFORM_FILTER_ASSERT_SVH

// condition implies consequence in the same cycle
`define RPT_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("rpt assertion failed");

// condition implies consequence in the following cycle
`define RPT_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("rpt assertion failed");

`endif

// ----- rtl/rpt_pkg.sv -----
// types, widths and register map of the rigid point transform filter
// depends on nothing; imported by every module of the block
`timescale 1ns / 1ps

package rpt_pkg;

   localparam int COORD_W = 32;
   localparam int COEF_W  = 16;
   localparam int ROW_W   = 3 * COEF_W;
   localparam int FRAC_W  = 14;
   localparam int PROD_W  = COEF_W + COORD_W;
   localparam int ACC_W   = PROD_W + 2;
   localparam int SQ_W    = 2 * COORD_W;
   localparam int DATA_W  = 64;
   localparam int ADDR_W  = 6;

   localparam logic [ROW_W-1:0] ROT_X_RESET = 48'h0000_0000_4000;
   localparam logic [ROW_W-1:0] ROT_Y_RESET = 48'h0000_4000_0000;
   localparam logic [ROW_W-1:0] ROT_Z_RESET = 48'h4000_0000_0000;

   // register index, byte address is eight times the index
   typedef enum logic [2:0] {
      CSR_ROT_X     = 3'd0,
      CSR_ROT_Y     = 3'd1,
      CSR_ROT_Z     = 3'd2,
      CSR_TRANS_XY  = 3'd3,
      CSR_TRANS_Z   = 3'd4,
      CSR_RANGE_LIM = 3'd5,
      CSR_RANGE_EN  = 3'd6
   } csr_index_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] px;
      logic signed [COORD_W-1:0] py;
      logic signed [COORD_W-1:0] pz;
      logic                      point_invalid;
   } req_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] qx;
      logic signed [COORD_W-1:0] qy;
      logic signed [COORD_W-1:0] qz;
   } rsp_type;

   // configuration as seen by the datapath
   typedef struct packed {
      logic [ROW_W-1:0]          rot_x;
      logic [ROW_W-1:0]          rot_y;
      logic [ROW_W-1:0]          rot_z;
      logic signed [COORD_W-1:0] trans_x;
      logic signed [COORD_W-1:0] trans_y;
      logic signed [COORD_W-1:0] trans_z;
      logic [COORD_W-1:0]        range_limit;
      logic                      range_enable;
   } cfg_type;

endpackage

// ----- rtl/rpt_csr.sv -----
// configuration registers behind the APB-style port
// depends on rpt_pkg
`timescale 1ns / 1ps

module rpt_csr
   import rpt_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [ADDR_W-1:0] paddr,
   input  logic [DATA_W-1:0] pwdata,
   output logic [DATA_W-1:0] prdata,
   output logic              pready,
   output cfg_type           cfg
);

   cfg_type       cfg_ff;
   csr_index_type index;
   logic          wr_en;

   assign index  = csr_index_type'(paddr[ADDR_W-1:3]);
   assign wr_en  = psel && penable && pwrite;
   assign pready = 1'b1;
   assign cfg    = cfg_ff;

   // register writes, unknown index ignored
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.rot_x        <= ROT_X_RESET;
         cfg_ff.rot_y        <= ROT_Y_RESET;
         cfg_ff.rot_z        <= ROT_Z_RESET;
         cfg_ff.trans_x      <= '0;
         cfg_ff.trans_y      <= '0;
         cfg_ff.trans_z      <= '0;
         cfg_ff.range_limit  <= '0;
         cfg_ff.range_enable <= 1'b0;
      end else if (wr_en) begin
         case (index)
            CSR_ROT_X: begin
               cfg_ff.rot_x <= pwdata[ROW_W-1:0];
            end
            CSR_ROT_Y: begin
               cfg_ff.rot_y <= pwdata[ROW_W-1:0];
            end
            CSR_ROT_Z: begin
               cfg_ff.rot_z <= pwdata[ROW_W-1:0];
            end
            CSR_TRANS_XY: begin
               cfg_ff.trans_x <= pwdata[COORD_W-1:0];
               cfg_ff.trans_y <= pwdata[2*COORD_W-1:COORD_W];
            end
            CSR_TRANS_Z: begin
               cfg_ff.trans_z <= pwdata[COORD_W-1:0];
            end
            CSR_RANGE_LIM: begin
               cfg_ff.range_limit <= pwdata[COORD_W-1:0];
            end
            CSR_RANGE_EN: begin
               cfg_ff.range_enable <= pwdata[0];
            end
            default: begin
            end
         endcase
      end
   end

   // read-back mux
   always_comb begin
      prdata = '0;
      case (index)
         CSR_ROT_X:     prdata = {{(DATA_W-ROW_W){1'b0}}, cfg_ff.rot_x};
         CSR_ROT_Y:     prdata = {{(DATA_W-ROW_W){1'b0}}, cfg_ff.rot_y};
         CSR_ROT_Z:     prdata = {{(DATA_W-ROW_W){1'b0}}, cfg_ff.rot_z};
         CSR_TRANS_XY:  prdata = {cfg_ff.trans_y, cfg_ff.trans_x};
         CSR_TRANS_Z:   prdata = {{(DATA_W-COORD_W){1'b0}}, cfg_ff.trans_z};
         CSR_RANGE_LIM: prdata = {{(DATA_W-COORD_W){1'b0}}, cfg_ff.range_limit};
         CSR_RANGE_EN:  prdata = {{(DATA_W-1){1'b0}}, cfg_ff.range_enable};
         default:       prdata = '0;
      endcase
   end

endmodule

// ----- rtl/rpt_lane.sv -----
// one output coordinate: multiply, sum with translation, round and saturate
// depends on rpt_pkg; three register stages, last one drives the result
`timescale 1ns / 1ps

module rpt_lane
   import rpt_pkg::*;
(
   input  logic                      clock,
   input  logic [ROW_W-1:0]          row,
   input  logic signed [COORD_W-1:0] trans,
   input  logic signed [COORD_W-1:0] px,
   input  logic signed [COORD_W-1:0] py,
   input  logic signed [COORD_W-1:0] pz,
   output logic signed [COORD_W-1:0] q
);

   localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(1) << (FRAC_W - 1);
   localparam int SHIFT_W = ACC_W - FRAC_W;

   logic signed [PROD_W-1:0]  prod_in [3];
   logic signed [PROD_W-1:0]  prod_ff [3];
   logic signed [COORD_W-1:0] trans_ff;
   logic signed [ACC_W-1:0]   acc_in;
   logic signed [ACC_W-1:0]   acc_ff;
   logic [SHIFT_W-1:0]        shifted;
   logic signed [COORD_W-1:0] q_in;
   logic signed [COORD_W-1:0] q_ff;

   // stage 1: coefficient times coordinate
   always_comb begin
      prod_in[0] = PROD_W'($signed(row[COEF_W-1:0])) * PROD_W'(px);
      prod_in[1] = PROD_W'($signed(row[2*COEF_W-1:COEF_W])) * PROD_W'(py);
      prod_in[2] = PROD_W'($signed(row[3*COEF_W-1:2*COEF_W])) * PROD_W'(pz);
   end

   // stage 2: sum of products, aligned translation and rounding half
   always_comb begin
      acc_in = {{(ACC_W-PROD_W){prod_ff[0][PROD_W-1]}}, prod_ff[0]}
             + {{(ACC_W-PROD_W){prod_ff[1][PROD_W-1]}}, prod_ff[1]}
             + {{(ACC_W-PROD_W){prod_ff[2][PROD_W-1]}}, prod_ff[2]}
             + {{(ACC_W-COORD_W-FRAC_W){trans_ff[COORD_W-1]}}, trans_ff, {FRAC_W{1'b0}}}
             + ROUND_HALF;
   end

   // stage 3: floor shift and saturate to the coordinate width
   always_comb begin
      shifted = acc_ff[ACC_W-1:FRAC_W];
      if (&shifted[SHIFT_W-1:COORD_W-1] || !(|shifted[SHIFT_W-1:COORD_W-1])) begin
         q_in = shifted[COORD_W-1:0];
      end else if (shifted[SHIFT_W-1]) begin
         q_in = {1'b1, {(COORD_W-1){1'b0}}};
      end else begin
         q_in = {1'b0, {(COORD_W-1){1'b1}}};
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      prod_ff  <= prod_in;
      trans_ff <= trans;
      acc_ff   <= acc_in;
      q_ff     <= q_in;
   end

   assign q = q_ff;

endmodule

// ----- rtl/rpt_range.sv -----
// range test on the untransformed point: squares, sum, compare with limit squared
// depends on rpt_pkg; two register stages, compare result feeds the output valid
`timescale 1ns / 1ps

module rpt_range
   import rpt_pkg::*;
(
   input  logic                      clock,
   input  logic signed [COORD_W-1:0] px,
   input  logic signed [COORD_W-1:0] py,
   input  logic signed [COORD_W-1:0] pz,
   input  logic [COORD_W-1:0]        range_limit,
   input  logic                      range_enable,
   output logic                      keep
);

   logic [COORD_W-1:0] abs_v [3];
   logic [SQ_W-1:0]    sq_in [3];
   logic [SQ_W-1:0]    sq_ff [3];
   logic [SQ_W-1:0]    lim_sq_in;
   logic [SQ_W-1:0]    lim_sq_ff;
   logic [SQ_W-1:0]    lim_sq2_ff;
   logic [SQ_W-1:0]    r2_in;
   logic [SQ_W-1:0]    r2_ff;

   // stage 1: magnitudes squared, limit squared
   always_comb begin
      abs_v[0] = px[COORD_W-1] ? COORD_W'(-px) : COORD_W'(px);
      abs_v[1] = py[COORD_W-1] ? COORD_W'(-py) : COORD_W'(py);
      abs_v[2] = pz[COORD_W-1] ? COORD_W'(-pz) : COORD_W'(pz);
      for (int i = 0; i < 3; i++) begin
         sq_in[i] = SQ_W'(abs_v[i]) * SQ_W'(abs_v[i]);
      end
      lim_sq_in = SQ_W'(range_limit) * SQ_W'(range_limit);
   end

   // stage 2: squared range, cannot overflow 64 bits
   assign r2_in = sq_ff[0] + sq_ff[1] + sq_ff[2];

   always_ff @(posedge clock) begin
      sq_ff      <= sq_in;
      lim_sq_ff  <= lim_sq_in;
      r2_ff      <= r2_in;
      lim_sq2_ff <= lim_sq_ff;
   end

   // a point exactly at the limit is kept
   assign keep = !range_enable || (r2_ff <= lim_sq2_ff);

endmodule

// ----- rtl/rigid_point_transform_filter.sv -----
// result strobe is registered; its valid bit travels beside the input register and the three lane stages
// throughput: one item per cycle, set by the three-stage multiply/add/round lanes
// busy stays low; the result side is never stalled
// reset clears all valid bits and loads the identity transform with range test off
// top level: input register, three coordinate lanes, range test, config port
// depends on rpt_pkg, rpt_csr, rpt_lane, rpt_range
`timescale 1ns / 1ps

module rigid_point_transform_filter
   import rpt_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  req_type           req_data,
   output logic              rsp_valid,
   output rsp_type           rsp_data,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [ADDR_W-1:0] paddr,
   input  logic [DATA_W-1:0] pwdata,
   output logic [DATA_W-1:0] prdata,
   output logic              pready
);

   cfg_type cfg;
   req_type req_ff;
   logic    s0_valid_in;
   logic    s0_valid_ff;
   logic    s1_valid_ff;
   logic    s2_valid_ff;
   logic    rsp_valid_in;
   logic    rsp_valid_ff;
   logic    keep;

   assign busy = 1'b0;

   // configuration port
   rpt_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   // input register, invalid points enter as bubbles
   assign s0_valid_in = start && !busy && !req_data.point_invalid;

   always_ff @(posedge clock) begin
      req_ff <= req_data;
   end

   // valid bits travel beside the lane stages
   assign rsp_valid_in = s2_valid_ff && keep;

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff  <= 1'b0;
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s0_valid_ff  <= s0_valid_in;
         s1_valid_ff  <= s0_valid_ff;
         s2_valid_ff  <= s1_valid_ff;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   // coordinate lanes
   rpt_lane u_lane_x (
      .clock (clock),
      .row   (cfg.rot_x),
      .trans (cfg.trans_x),
      .px    (req_ff.px),
      .py    (req_ff.py),
      .pz    (req_ff.pz),
      .q     (rsp_data.qx)
   );

   rpt_lane u_lane_y (
      .clock (clock),
      .row   (cfg.rot_y),
      .trans (cfg.trans_y),
      .px    (req_ff.px),
      .py    (req_ff.py),
      .pz    (req_ff.pz),
      .q     (rsp_data.qy)
   );

   rpt_lane u_lane_z (
      .clock (clock),
      .row   (cfg.rot_z),
      .trans (cfg.trans_z),
      .px    (req_ff.px),
      .py    (req_ff.py),
      .pz    (req_ff.pz),
      .q     (rsp_data.qz)
   );

   // range test on the untransformed point
   rpt_range u_range (
      .clock        (clock),
      .px           (req_ff.px),
      .py           (req_ff.py),
      .pz           (req_ff.pz),
      .range_limit  (cfg.range_limit),
      .range_enable (cfg.range_enable),
      .keep         (keep)
   );

endmodule

// ----- rtl/rpt_checker.sv -----
// port-level checks of the rigid point transform filter, bound to the top level
// depends on rpt_pkg and rigid_point_transform_filter_assert.svh
`timescale 1ns / 1ps
`include "rigid_point_transform_filter_assert.svh"

module rpt_checker
   import rpt_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    start,
   input logic    busy,
   input req_type req_data,
   input logic    rsp_valid
);

   // the pipeline never pushes back
   `RPT_ASSERT_NOW(a_never_busy, clock, reset, 1'b1, !busy)

   // an invalid point gives no result
   `RPT_ASSERT_NOW(a_invalid_dropped, clock, reset,
      start && !busy && req_data.point_invalid, ##4 !rsp_valid)

   // every result comes from an item that was taken
   `RPT_ASSERT_NOW(a_result_has_item, clock, reset,
      rsp_valid, $past(start && !busy && !req_data.point_invalid, 4))

   // nothing comes out right after reset
   `RPT_ASSERT_NEXT(a_quiet_after_reset, clock, reset, $fell(reset), !rsp_valid)

endmodule

bind rigid_point_transform_filter rpt_checker u_rpt_checker (.*);
